// ----- src/oems_pkg.sv -----
// Shared types, sizes and the network partner function for the odd-even merge sorter.
package oems_pkg;

    // Set size and derived widths
    localparam int NUM_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(NUM_ELEMENTS);
    localparam int CNT_W        = $clog2(NUM_ELEMENTS + 1);
    localparam int LOG_N        = $clog2(NUM_ELEMENTS);
    localparam int NUM_STAGES   = LOG_N * (LOG_N + 1) / 2;
    localparam int STAGE_W      = $clog2(NUM_STAGES + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Filler for unused slots: never moves under a strict compare-exchange
    localparam logic signed [31:0] PAD_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
    } out_word_t;

    // One queued word: the value and whether it closes its set
    typedef struct packed {
        logic signed [31:0] value;
        logic               close;
    } queue_entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QLVL_W-1:0] level;
    } queue_stat_t;

    // Partner of slot x in network stage s; x itself when x sits out the stage.
    // Stages run p = 1, 2, 4, ... and, within each, k = p down to 1.
    function automatic int cex_partner(int s, int x);
        int c;
        int p;
        int k;
        int off;
        int res;
        c   = 0;
        p   = 1;
        k   = 1;
        res = x;
        for (int lp = 0; lp < LOG_N; lp++) begin
            for (int lk = lp; lk >= 0; lk--) begin
                if (c == s) begin
                    p = 1 << lp;
                    k = 1 << lk;
                end
                c++;
            end
        end
        off = k & (p - 1);
        if ((x >= off) && (((x - off) & (2 * k - 1)) < k) && (x + k < NUM_ELEMENTS) &&
            ((x & ~(2 * p - 1)) == ((x + k) & ~(2 * p - 1)))) begin
            res = x + k;
        end else if ((x - k >= off) && (((x - k - off) & (2 * k - 1)) < k) &&
                     ((x & ~(2 * p - 1)) == ((x - k) & ~(2 * p - 1)))) begin
            res = x - k;
        end
        return res;
    endfunction

endpackage

// ----- src/oems_front.sv -----
// Front end: accepts input words, tracks set length and tags set-closing words.
module oems_front
    import oems_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  in_word_t     item,
    input  queue_stat_t  q_stat,
    output logic         push,
    output queue_entry_t push_entry
);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             close;

    // Accept whenever the queue has room
    assign item_ready = !q_stat.full;
    assign push       = item_valid && item_ready;

    // Close the set on last or when it fills up
    assign close = item.last || (cnt_reg == IDX_W'(NUM_ELEMENTS - 1));

    assign push_entry.value = item.value;
    assign push_entry.close = close;

    // Advance the element count, restart after a closing word
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            cnt_next = close ? '0 : cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/oems_queue.sv -----
// Short word queue between the front end and the sorting back end.
module oems_queue
    import oems_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head,
    output queue_stat_t  q_stat
);

    queue_entry_t      store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QLVL_W-1:0] level_reg;
    logic [QLVL_W-1:0] level_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.level = level_reg;
    assign head         = store_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // Advance pointers with explicit wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   level_next = level_reg + QLVL_W'(1);
            2'b01:   level_next = level_reg - QLVL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- src/oems_back.sv -----
// Back end: loads a set, runs the compare-exchange network, emits in order.
module oems_back
    import oems_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  queue_entry_t head,
    input  queue_stat_t  q_stat,
    output logic         pop,
    output logic         emitting,
    output logic         result_valid,
    input  logic         result_ready,
    output out_word_t    result
);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_SORT = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [STAGE_W-1:0] stage_reg;
    logic [STAGE_W-1:0] stage_next;
    logic signed [31:0] elem_reg [NUM_ELEMENTS];
    logic signed [31:0] elem_next [NUM_ELEMENTS];
    logic signed [31:0] sorted_next [NUM_ELEMENTS];
    out_word_t          out_reg;
    out_word_t          out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               emit_take;

    assign pop          = (state_reg == ST_LOAD) && !q_stat.empty;
    assign emitting     = (state_reg == ST_EMIT);
    assign emit_take    = emitting && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Apply one network stage to every slot: low side keeps min, high side max
    always_comb
    begin
        logic signed [31:0] pv;
        pv = '0;
        for (int x = 0; x < NUM_ELEMENTS; x++)
        begin
            sorted_next[x] = elem_reg[x];
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                if (stage_reg == STAGE_W'(s))
                begin
                    pv = elem_reg[cex_partner(s, x)];
                    if (cex_partner(s, x) > x)
                    begin
                        sorted_next[x] = (elem_reg[x] > pv) ? pv : elem_reg[x];
                    end
                    else if (cex_partner(s, x) < x)
                    begin
                        sorted_next[x] = (pv > elem_reg[x]) ? pv : elem_reg[x];
                    end
                end
            end
        end
    end

    // Select the store update for the current phase
    always_comb
    begin
        for (int x = 0; x < NUM_ELEMENTS; x++)
        begin
            elem_next[x] = elem_reg[x];
        end
        case (state_reg)
            ST_LOAD:
            begin
                for (int x = 0; x < NUM_ELEMENTS; x++)
                begin
                    if (pop && (cnt_reg[IDX_W-1:0] == IDX_W'(x)))
                    begin
                        elem_next[x] = head.value;
                    end
                end
            end
            ST_PAD:
            begin
                for (int x = 0; x < NUM_ELEMENTS; x++)
                begin
                    if (CNT_W'(x) >= cnt_reg)
                    begin
                        elem_next[x] = PAD_VALUE;
                    end
                end
            end
            ST_SORT:
            begin
                for (int x = 0; x < NUM_ELEMENTS; x++)
                begin
                    elem_next[x] = sorted_next[x];
                end
            end
            ST_EMIT:
            begin
                if (emit_take)
                begin
                    for (int x = 0; x < NUM_ELEMENTS - 1; x++)
                    begin
                        elem_next[x] = elem_reg[x + 1];
                    end
                    elem_next[NUM_ELEMENTS-1] = PAD_VALUE;
                end
            end
            default:
            begin
                for (int x = 0; x < NUM_ELEMENTS; x++)
                begin
                    elem_next[x] = elem_reg[x];
                end
            end
        endcase
    end

    // Sequence the phases and counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (head.close)
                    begin
                        state_next = ST_PAD;
                        stage_next = '0;
                    end
                end
            end
            ST_PAD:
            begin
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                stage_next = stage_reg + STAGE_W'(1);
                if (stage_reg == STAGE_W'(NUM_STAGES - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_take)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    // Load the output register from the head slot, drop it once taken
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit_take)
        begin
            out_next.sorted_value = elem_reg[0];
            out_next.final_res    = (cnt_reg == CNT_W'(1));
            out_valid_next        = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold store and output word
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        for (int x = 0; x < NUM_ELEMENTS; x++)
        begin
            elem_reg[x] <= elem_next[x];
        end
    end

endmodule

// ----- src/odd_even_merge_sorter.sv -----
// Top level of the odd-even merge sorter: front end, queue and sorting back end.
// The back end drains the queue one word a cycle while loading and the queue is not empty.
// After the closing word leaves the queue: a pad step, then the log2(N)*(log2(N)+1)/2 network
// stages in turn (10 for 16 slots), then one word per cycle out while result_ready is high.
// Reset clears the handshake, the queue and the sequencer; the element store is not cleared.
module odd_even_merge_sorter
    import oems_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    queue_stat_t  q_stat;
    queue_entry_t push_entry;
    queue_entry_t head;
    logic         push;
    logic         pop;
    logic         emitting;

    oems_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    oems_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    oems_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .emitting     (emitting),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Queue fill level never passes its depth
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // A new result only comes out of the emit phase
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(emitting))
        else $error("result raised outside emit phase");

    // Hold a waiting result word steady until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("result word changed or dropped while waiting");

endmodule
